[src/amg_pkg.sv]
`timescale 1ns / 1ps

package amg_pkg;

    localparam int MAX_VERTICES_DEF = 16;
    localparam int FIELD_LIMIT      = 16;

    localparam int OP_W     = 2;
    localparam int VERTEX_W = 4;
    localparam int COUNT_W  = 5;
    localparam int STATUS_W = 2;

    localparam logic [COUNT_W-1:0] VERTEX_COUNT_RESET = 5'd16;

    // Operation codes carried by the opcode field.
    localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd1;
    localparam logic [OP_W-1:0] OP_LIST  = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE  = 2'd3;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RDA,
        S_RDB,
        S_ONE,
        S_LIST
    } state_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                adjacent;
        logic [VERTEX_W-1:0] neighbor;
        logic [COUNT_W-1:0]  neighbor_count;
        logic                last;
    } result_t;

    typedef struct packed {
        logic load;
        logic step;
    } scan_ctl_t;

    typedef struct packed {
        logic [VERTEX_W-1:0] neighbor;
        logic [COUNT_W-1:0]  count;
        logic                last;
    } scan_stat_t;

endpackage

[src/amg_ram.sv]
`timescale 1ns / 1ps

module amg_ram #(
    parameter int WIDTH = amg_pkg::MAX_VERTICES_DEF,
    parameter int DEPTH = amg_pkg::MAX_VERTICES_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[src/amg_scan.sv]
`timescale 1ns / 1ps

module amg_scan #(
    parameter int MAX_VERTICES = amg_pkg::MAX_VERTICES_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  amg_pkg::scan_ctl_t      ctl,
    input  logic [MAX_VERTICES-1:0] row_in,
    output amg_pkg::scan_stat_t     stat
);

    localparam int LW = (MAX_VERTICES < amg_pkg::FIELD_LIMIT) ?
                        MAX_VERTICES : amg_pkg::FIELD_LIMIT;

    logic [MAX_VERTICES-1:0]      row_reg;
    logic [MAX_VERTICES-1:0]      row_next;
    logic [amg_pkg::COUNT_W-1:0]  cnt_reg;
    logic [amg_pkg::VERTEX_W-1:0] low_idx;

    // The lowest set bit is the next neighbor in ascending order.
    always_comb
    begin
        low_idx = '0;
        for (int i = LW - 1; i >= 0; i--)
        begin
            if (row_reg[i])
            begin
                low_idx = amg_pkg::VERTEX_W'(i);
            end
        end
    end

    assign row_next = row_reg & (row_reg - MAX_VERTICES'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (ctl.load)
        begin
            cnt_reg <= '0;
        end
        else if (ctl.step)
        begin
            cnt_reg <= cnt_reg + amg_pkg::COUNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            row_reg <= row_in;
        end
        else if (ctl.step)
        begin
            row_reg <= row_next;
        end
    end

    assign stat.neighbor = low_idx;
    assign stat.count    = cnt_reg + amg_pkg::COUNT_W'(1);
    assign stat.last     = (row_next == '0);

endmodule

[src/amg_ctrl.sv]
`timescale 1ns / 1ps

module amg_ctrl #(
    parameter int MAX_VERTICES = amg_pkg::MAX_VERTICES_DEF,
    parameter int AW           = $clog2(MAX_VERTICES)
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [amg_pkg::OP_W-1:0]       opcode,
    input  logic [amg_pkg::VERTEX_W-1:0]   vertex_a,
    input  logic [amg_pkg::VERTEX_W-1:0]   vertex_b,
    input  logic [amg_pkg::COUNT_W-1:0]    active_n,
    output logic                           ram_we,
    output logic [AW-1:0]                  ram_waddr,
    output logic [MAX_VERTICES-1:0]        ram_wdata,
    output logic                           ram_re,
    output logic [AW-1:0]                  ram_raddr,
    input  logic [MAX_VERTICES-1:0]        ram_rdata,
    output amg_pkg::scan_ctl_t             scan_ctl,
    output logic [MAX_VERTICES-1:0]        scan_row,
    input  amg_pkg::scan_stat_t            scan_stat,
    output logic                           res_valid,
    input  logic                           res_ready,
    output amg_pkg::result_t               res
);

    amg_pkg::state_t                state_reg;
    amg_pkg::state_t                state_next;
    logic [amg_pkg::OP_W-1:0]       op_reg;
    logic [amg_pkg::VERTEX_W-1:0]   a_reg;
    logic [amg_pkg::VERTEX_W-1:0]   b_reg;
    logic [amg_pkg::STATUS_W-1:0]   status_pend_reg;
    logic                           adj_pend_reg;
    logic [MAX_VERTICES-1:0]        valid_reg;

    logic                           accept;
    logic                           range_ok;
    logic [AW-1:0]                  row_addr;
    logic [MAX_VERTICES-1:0]        row_eff;
    logic [MAX_VERTICES-1:0]        active_mask;
    logic [MAX_VERTICES-1:0]        row_listed;

    assign in_stall = (state_reg != amg_pkg::S_IDLE);
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        if (opcode == amg_pkg::OP_LIST)
        begin
            range_ok = ({1'b0, vertex_a} < active_n);
        end
        else
        begin
            range_ok = ({1'b0, vertex_a} < active_n) && ({1'b0, vertex_b} < active_n);
        end
    end

    // A row never written since reset reads as empty.
    assign row_addr = (state_reg == amg_pkg::S_RDB) ? AW'(b_reg) : AW'(a_reg);
    assign row_eff  = valid_reg[row_addr] ? ram_rdata : '0;

    always_comb
    begin
        active_mask = '0;
        for (int i = 0; i < MAX_VERTICES; i++)
        begin
            if (i < amg_pkg::FIELD_LIMIT)
            begin
                active_mask[i] = (amg_pkg::COUNT_W'(i) < active_n);
            end
        end
    end

    assign row_listed = row_eff & active_mask;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            amg_pkg::S_IDLE:
            begin
                if (accept && opcode != amg_pkg::OP_NONE)
                begin
                    state_next = range_ok ? amg_pkg::S_RDA : amg_pkg::S_ONE;
                end
            end
            amg_pkg::S_RDA:
            begin
                unique case (op_reg)
                    amg_pkg::OP_ADD:
                    begin
                        state_next = (a_reg != b_reg) ? amg_pkg::S_RDB : amg_pkg::S_ONE;
                    end
                    amg_pkg::OP_LIST:
                    begin
                        state_next = (row_listed == '0) ? amg_pkg::S_ONE : amg_pkg::S_LIST;
                    end
                    default:
                    begin
                        state_next = amg_pkg::S_ONE;
                    end
                endcase
            end
            amg_pkg::S_RDB:
            begin
                state_next = amg_pkg::S_ONE;
            end
            amg_pkg::S_ONE:
            begin
                if (res_ready)
                begin
                    state_next = amg_pkg::S_IDLE;
                end
            end
            amg_pkg::S_LIST:
            begin
                if (res_ready && scan_stat.last)
                begin
                    state_next = amg_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = amg_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ram_re        = 1'b0;
        ram_raddr     = AW'(vertex_a);
        ram_we        = 1'b0;
        ram_waddr     = AW'(a_reg);
        ram_wdata     = row_eff | (MAX_VERTICES'(1) << b_reg);
        scan_ctl.load = 1'b0;
        scan_ctl.step = 1'b0;
        scan_row      = row_listed;
        res_valid     = 1'b0;
        res           = '0;
        unique case (state_reg)
            amg_pkg::S_IDLE:
            begin
                ram_re = accept && (opcode != amg_pkg::OP_NONE) && range_ok;
            end
            amg_pkg::S_RDA:
            begin
                if (op_reg == amg_pkg::OP_ADD)
                begin
                    ram_we    = 1'b1;
                    ram_re    = (a_reg != b_reg);
                    ram_raddr = AW'(b_reg);
                end
                scan_ctl.load = (op_reg == amg_pkg::OP_LIST);
            end
            amg_pkg::S_RDB:
            begin
                ram_we    = 1'b1;
                ram_waddr = AW'(b_reg);
                ram_wdata = row_eff | (MAX_VERTICES'(1) << a_reg);
            end
            amg_pkg::S_ONE:
            begin
                res_valid    = 1'b1;
                res.status   = status_pend_reg;
                res.adjacent = adj_pend_reg;
                res.last     = 1'b1;
            end
            amg_pkg::S_LIST:
            begin
                res_valid          = 1'b1;
                res.status         = amg_pkg::ST_OK;
                res.neighbor       = scan_stat.neighbor;
                res.neighbor_count = scan_stat.count;
                res.last           = scan_stat.last;
                scan_ctl.step      = res_ready;
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= amg_pkg::S_IDLE;
            valid_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (ram_we)
            begin
                valid_reg[ram_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg          <= opcode;
            a_reg           <= vertex_a;
            b_reg           <= vertex_b;
            status_pend_reg <= range_ok ? amg_pkg::ST_OK : amg_pkg::ST_RANGE;
            adj_pend_reg    <= 1'b0;
        end
        else if (state_reg == amg_pkg::S_RDA)
        begin
            if (op_reg == amg_pkg::OP_QUERY)
            begin
                adj_pend_reg <= row_eff[AW'(b_reg)];
            end
            if (op_reg == amg_pkg::OP_LIST && row_listed == '0)
            begin
                status_pend_reg <= amg_pkg::ST_EMPTY;
            end
        end
    end

endmodule

[src/adjacency_matrix_graph_store.sv]
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// request   in         in_valid / in_stall  opcode, vertex_a, vertex_b
// result    out        out_valid/out_stall  status, adjacent, neighbor, neighbor_count, last
// config    in         cfg_wr_en            cfg_wr_data (vertex count)
//
// A request is taken only while the controller is idle. Add edge reads row a, writes it
// back while reading row b, then writes row b and gives its result; a self loop skips
// row b. Query reads its row, an out-of-range request goes straight to its result, and
// a listing gives one result per neighbor, or a single one if there are none. The adjacency
// store is empty right after reset: per-row valid bits make every unwritten row read as
// zero, so no clearing pass is needed. A stalled result sits in the output register
// while the next request is already accepted; a listing simply pauses while the result
// side stalls.

module adjacency_matrix_graph_store #(
    parameter int MAX_VERTICES = amg_pkg::MAX_VERTICES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [amg_pkg::COUNT_W-1:0]      cfg_wr_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [amg_pkg::OP_W-1:0]         opcode,
    input  logic [amg_pkg::VERTEX_W-1:0]     vertex_a,
    input  logic [amg_pkg::VERTEX_W-1:0]     vertex_b,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [amg_pkg::STATUS_W-1:0]     status,
    output logic                             adjacent,
    output logic [amg_pkg::VERTEX_W-1:0]     neighbor,
    output logic [amg_pkg::COUNT_W-1:0]      neighbor_count,
    output logic                             last
);

    localparam int AW = $clog2(MAX_VERTICES);

    // The usable vertex count is capped by the store size and by the 4-bit vertex fields.
    localparam int LIMIT_INT = (MAX_VERTICES < amg_pkg::FIELD_LIMIT) ?
                               MAX_VERTICES : amg_pkg::FIELD_LIMIT;
    localparam logic [amg_pkg::COUNT_W-1:0] LIMIT = amg_pkg::COUNT_W'(LIMIT_INT);

    logic [amg_pkg::COUNT_W-1:0] vertex_count_reg;
    logic [amg_pkg::COUNT_W-1:0] active_n;

    logic                        ram_we;
    logic [AW-1:0]               ram_waddr;
    logic [MAX_VERTICES-1:0]     ram_wdata;
    logic                        ram_re;
    logic [AW-1:0]               ram_raddr;
    logic [MAX_VERTICES-1:0]     ram_rdata;

    amg_pkg::scan_ctl_t          scan_ctl;
    amg_pkg::scan_stat_t         scan_stat;
    logic [MAX_VERTICES-1:0]     scan_row;

    logic                        res_valid;
    logic                        res_ready;
    amg_pkg::result_t            res;

    logic                        out_valid_reg;
    logic                        out_valid_next;
    amg_pkg::result_t            out_res_reg;

    // Vertex count register; the user must write it only while the block is idle, which the block does not enforce.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_count_reg <= amg_pkg::VERTEX_COUNT_RESET;
        end
        else if (cfg_wr_en)
        begin
            vertex_count_reg <= cfg_wr_data;
        end
    end

    assign active_n = (vertex_count_reg > LIMIT) ? LIMIT : vertex_count_reg;

    amg_ctrl #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .opcode    (opcode),
        .vertex_a  (vertex_a),
        .vertex_b  (vertex_b),
        .active_n  (active_n),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .scan_ctl  (scan_ctl),
        .scan_row  (scan_row),
        .scan_stat (scan_stat),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // One row per vertex, one bit per possible neighbor.
    amg_ram #(
        .WIDTH (MAX_VERTICES),
        .DEPTH (MAX_VERTICES)
    ) u_rows (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Walks a latched row from the lowest set bit upward, one neighbor per result.
    amg_scan #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_scan (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (scan_ctl),
        .row_in (scan_row),
        .stat   (scan_stat)
    );

    // Output register: it takes a new result whenever it is empty or being drained.
    assign res_ready = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_ready)
        begin
            out_valid_next = res_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_res_reg <= res;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = out_res_reg.status;
    assign adjacent       = out_res_reg.adjacent;
    assign neighbor       = out_res_reg.neighbor;
    assign neighbor_count = out_res_reg.neighbor_count;
    assign last           = out_res_reg.last;

    // Error and empty-listing results always close their request.
    a_nonok_is_last: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid && (status != amg_pkg::ST_OK) |-> last
    ) else $error("non-ok result without last flag");

    // A neighbor count only ever comes with a plain listed neighbor.
    a_count_only_listing: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid && (neighbor_count != '0) |-> (status == amg_pkg::ST_OK) && !adjacent
    ) else $error("neighbor count on a non-listing result");

    // An unused opcode is dropped at once and leaves the block idle.
    a_unused_op_idle: assert property (
        @(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (opcode == amg_pkg::OP_NONE) |=> !in_stall
    ) else $error("unused opcode occupied the controller");

    // Both symmetric writes of an add edge happen on consecutive cycles.
    a_add_pair: assert property (
        @(posedge clk) disable iff (!rst_n)
        ram_we && ram_re |=> ram_we
    ) else $error("second half of an edge insert missing");

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

    // Cycles with no request and no result accepted before the run is declared hung.
    // The longest legal quiet stretch is a long random idle streak on either side or
    // a drain before a count write, both far below this.
    localparam int WATCHDOG_LIMIT = 4000;

    // Cycles to let pass after the last pending result before a count write.
    localparam int DRAIN_CYCLES = 8;

    logic                         clk            = 1'b0;
    logic                         rst_n          = 1'b0;
    logic                         cfg_wr_en      = 1'b0;
    logic [amg_pkg::COUNT_W-1:0]  cfg_wr_data    = '0;
    logic                         in_valid       = 1'b0;
    logic                         in_stall;
    logic [amg_pkg::OP_W-1:0]     opcode         = amg_pkg::OP_ADD;
    logic [amg_pkg::VERTEX_W-1:0] vertex_a       = '0;
    logic [amg_pkg::VERTEX_W-1:0] vertex_b       = '0;
    logic                         out_valid;
    logic                         out_stall      = 1'b0;
    logic [amg_pkg::STATUS_W-1:0] status;
    logic                         adjacent;
    logic [amg_pkg::VERTEX_W-1:0] neighbor;
    logic [amg_pkg::COUNT_W-1:0]  neighbor_count;
    logic                         last;

    // Percent chance per cycle that the sender or the receiver holds back.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    int error_count   = 0;
    int quiet_cycles  = 0;

    // Model state: the adjacency rows and the programmed vertex count.
    logic [amg_pkg::MAX_VERTICES_DEF-1:0] model_rows [amg_pkg::MAX_VERTICES_DEF];
    logic [amg_pkg::COUNT_W-1:0]          model_vertex_count = amg_pkg::VERTEX_COUNT_RESET;

    // Results still owed by the block, oldest first.
    amg_pkg::result_t pending_results [$];

    adjacency_matrix_graph_store dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .opcode         (opcode),
        .vertex_a       (vertex_a),
        .vertex_b       (vertex_b),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .adjacent       (adjacent),
        .neighbor       (neighbor),
        .neighbor_count (neighbor_count),
        .last           (last)
    );

    always #5 clk = ~clk;

    // The receiver decides at each falling edge whether to stall the coming edge.
    always @(negedge clk)
    begin
        out_stall <= rst_n && ($urandom_range(0, 99) < recv_idle_pct);
    end

    // Any accepted request or result counts as progress.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t ns: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("tb_top: errors");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Result checker. Each accepted result must match the oldest pending one exactly.
    always @(posedge clk)
    begin : result_checker
        amg_pkg::result_t got;
        amg_pkg::result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = {status, adjacent, neighbor, neighbor_count, last};
            if (pending_results.size() == 0)
            begin
                $display("%0t ns: unexpected result, got status=%0d adjacent=%0d",
                         $time, got.status, got.adjacent);
                $display("    neighbor=%0d count=%0d last=%0d",
                         got.neighbor, got.neighbor_count, got.last);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.status !== want.status || got.adjacent !== want.adjacent ||
                    got.neighbor !== want.neighbor ||
                    got.neighbor_count !== want.neighbor_count ||
                    got.last !== want.last)
                begin
                    $display("%0t ns: result mismatch", $time);
                    $display("    expected status=%0d adjacent=%0d neighbor=%0d count=%0d last=%0d",
                             want.status, want.adjacent, want.neighbor,
                             want.neighbor_count, want.last);
                    $display("    actual   status=%0d adjacent=%0d neighbor=%0d count=%0d last=%0d",
                             got.status, got.adjacent, got.neighbor,
                             got.neighbor_count, got.last);
                    error_count++;
                end
            end
        end
    end

    // The count the block actually uses: the programmed value, saturated at the
    // number of rows and at the width of the vertex fields.
    function automatic int active_vertices();
        int n;
        n = int'(model_vertex_count);
        if (n > amg_pkg::MAX_VERTICES_DEF) n = amg_pkg::MAX_VERTICES_DEF;
        if (n > amg_pkg::FIELD_LIMIT) n = amg_pkg::FIELD_LIMIT;
        return n;
    endfunction

    function automatic void owe_result(input logic [amg_pkg::STATUS_W-1:0] st,
                                       input logic adj,
                                       input logic [amg_pkg::VERTEX_W-1:0] nb,
                                       input logic [amg_pkg::COUNT_W-1:0] cnt,
                                       input logic fin);
        amg_pkg::result_t r;
        r.status         = st;
        r.adjacent       = adj;
        r.neighbor       = nb;
        r.neighbor_count = cnt;
        r.last           = fin;
        pending_results.push_back(r);
    endfunction

    // Applies one accepted request to the model graph and queues the results it causes.
    function automatic void apply_graph_request(input logic [amg_pkg::OP_W-1:0] op,
                                                input logic [amg_pkg::VERTEX_W-1:0] a,
                                                input logic [amg_pkg::VERTEX_W-1:0] b);
        int  n;
        int  total;
        int  emitted;
        bit  a_ok;
        bit  b_ok;
        n    = active_vertices();
        a_ok = int'(a) < n;
        b_ok = int'(b) < n;
        case (op)
            amg_pkg::OP_ADD:
            begin
                if (!a_ok || !b_ok)
                begin
                    owe_result(amg_pkg::ST_RANGE, 1'b0, '0, '0, 1'b1);
                end
                else
                begin
                    model_rows[a][b] = 1'b1;
                    model_rows[b][a] = 1'b1;
                    owe_result(amg_pkg::ST_OK, 1'b0, '0, '0, 1'b1);
                end
            end
            amg_pkg::OP_QUERY:
            begin
                if (!a_ok || !b_ok) owe_result(amg_pkg::ST_RANGE, 1'b0, '0, '0, 1'b1);
                else owe_result(amg_pkg::ST_OK, model_rows[a][b], '0, '0, 1'b1);
            end
            amg_pkg::OP_LIST:
            begin
                if (!a_ok)
                begin
                    owe_result(amg_pkg::ST_RANGE, 1'b0, '0, '0, 1'b1);
                end
                else
                begin
                    // Only vertices below the active count are listed, even when
                    // edges to higher vertices survive from a larger count.
                    total = 0;
                    for (int i = 0; i < n; i++) total += model_rows[a][i];
                    if (total == 0)
                    begin
                        owe_result(amg_pkg::ST_EMPTY, 1'b0, '0, '0, 1'b1);
                    end
                    else
                    begin
                        emitted = 0;
                        for (int i = 0; i < n; i++)
                        begin
                            if (model_rows[a][i])
                            begin
                                emitted++;
                                owe_result(amg_pkg::ST_OK, 1'b0, amg_pkg::VERTEX_W'(i),
                                           amg_pkg::COUNT_W'(emitted), emitted == total);
                            end
                        end
                    end
                end
            end
            default:
            begin
                // The unused opcode is dropped without a result or a change.
            end
        endcase
    endfunction

    // Offers one request, idling first at the sender's rate, and holds it until taken.
    // Valid stays high between back-to-back requests; it only drops during an idle cycle or a drain.
    task automatic send_request(input logic [amg_pkg::OP_W-1:0] op,
                                input logic [amg_pkg::VERTEX_W-1:0] a,
                                input logic [amg_pkg::VERTEX_W-1:0] b);
        begin
            @(negedge clk);
            while ($urandom_range(0, 99) < send_idle_pct)
            begin
                in_valid <= 1'b0;
                @(negedge clk);
            end
            in_valid <= 1'b1;
            opcode   <= op;
            vertex_a <= a;
            vertex_b <= b;
            @(posedge clk);
            while (in_stall) @(posedge clk);
            apply_graph_request(op, a, b);
        end
    endtask

    // Stops sending and waits until the block has delivered every pending result.
    task automatic hold_until_drained();
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            while (pending_results.size() != 0) @(negedge clk);
        end
    endtask

    // Rewrites the vertex count once the block is quiet.
    task automatic program_vertex_count(input logic [amg_pkg::COUNT_W-1:0] value);
        begin
            hold_until_drained();
            repeat (DRAIN_CYCLES) @(negedge clk);
            cfg_wr_en   <= 1'b1;
            cfg_wr_data <= value;
            @(negedge clk);
            cfg_wr_en   <= 1'b0;
            model_vertex_count = value;
        end
    endtask

    task automatic set_idling(input int sender_pct, input int receiver_pct);
        begin
            send_idle_pct = sender_pct;
            recv_idle_pct = receiver_pct;
        end
    endtask

    // Mostly in-range vertices so that edges pile up and listings grow long;
    // the rest spans the whole field to hit the range check.
    function automatic logic [amg_pkg::VERTEX_W-1:0] pick_vertex();
        int n;
        n = active_vertices();
        if (n > 0 && $urandom_range(0, 99) < 85)
            return amg_pkg::VERTEX_W'($urandom_range(0, n - 1));
        return amg_pkg::VERTEX_W'($urandom_range(0, 15));
    endfunction

    // A freshly reset store must read as empty at vertex 0 and at vertex 15.
    task automatic test_empty_store();
        begin
            send_request(amg_pkg::OP_LIST, 4'd0, 4'd0);
            send_request(amg_pkg::OP_QUERY, 4'd15, 4'd15);
            send_request(amg_pkg::OP_NONE, 4'd15, 4'd15);
        end
    endtask

    // Corner vertices, an edge added in the mirrored order, and a self loop.
    task automatic test_edges_and_self_loop();
        begin
            send_request(amg_pkg::OP_ADD, 4'd0, 4'd15);
            send_request(amg_pkg::OP_ADD, 4'd15, 4'd0);
            send_request(amg_pkg::OP_ADD, 4'd7, 4'd7);
            send_request(amg_pkg::OP_QUERY, 4'd15, 4'd0);
            send_request(amg_pkg::OP_QUERY, 4'd7, 4'd7);
            send_request(amg_pkg::OP_LIST, 4'd7, 4'd0);
        end
    endtask

    // One vertex joined to every vertex, itself included, gives the longest listing.
    task automatic test_full_neighbor_row();
        begin
            for (int x = 0; x < amg_pkg::MAX_VERTICES_DEF; x++)
            begin
                send_request(amg_pkg::OP_ADD, 4'd9, amg_pkg::VERTEX_W'(x));
            end
            send_request(amg_pkg::OP_LIST, 4'd9, 4'd0);
        end
    endtask

    // Random requests; the count excludes ignored opcodes. Every forty requests the
    // sender waits for the block to drain completely.
    task automatic test_random_traffic(input int requests);
        int sent;
        int roll;
        logic [amg_pkg::OP_W-1:0] op;
        begin
            sent = 0;
            while (sent < requests)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 40) op = amg_pkg::OP_ADD;
                else if (roll < 70) op = amg_pkg::OP_QUERY;
                else if (roll < 95) op = amg_pkg::OP_LIST;
                else op = amg_pkg::OP_NONE;
                send_request(op, pick_vertex(), pick_vertex());
                if (op != amg_pkg::OP_NONE)
                begin
                    sent++;
                    if (sent % 40 == 0) hold_until_drained();
                end
            end
        end
    endtask

    // Shrinking hides high vertices but keeps their edges for when the count grows.
    // A count above the limit must behave as the full sixteen.
    task automatic test_shrink_and_grow();
        begin
            program_vertex_count(5'd5);
            send_request(amg_pkg::OP_QUERY, 4'd0, 4'd15);
            send_request(amg_pkg::OP_LIST, 4'd0, 4'd0);
            test_random_traffic(50);
            program_vertex_count(5'd31);
            send_request(amg_pkg::OP_QUERY, 4'd15, 4'd0);
        end
    endtask

    task automatic test_single_vertex();
        begin
            program_vertex_count(5'd1);
            send_request(amg_pkg::OP_ADD, 4'd0, 4'd0);
            send_request(amg_pkg::OP_QUERY, 4'd0, 4'd1);
            send_request(amg_pkg::OP_LIST, 4'd0, 4'd0);
            test_random_traffic(15);
        end
    endtask

    // With no vertices every operation reports a range error.
    task automatic test_no_vertices();
        begin
            program_vertex_count(5'd0);
            send_request(amg_pkg::OP_ADD, 4'd0, 4'd0);
            send_request(amg_pkg::OP_QUERY, 4'd0, 4'd0);
            send_request(amg_pkg::OP_LIST, 4'd0, 4'd0);
        end
    endtask

    initial
    begin
        for (int i = 0; i < amg_pkg::MAX_VERTICES_DEF; i++) model_rows[i] = '0;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Slow receiver: results back up while requests keep coming.
        set_idling(26, 88);
        test_empty_store();
        test_edges_and_self_loop();
        test_full_neighbor_row();
        test_random_traffic(50);
        test_shrink_and_grow();

        // Slow sender: the block mostly sits idle between requests.
        set_idling(88, 26);
        test_random_traffic(45);
        test_single_vertex();
        test_no_vertices();

        // Full speed on both sides with the whole store back in view.
        set_idling(0, 0);
        program_vertex_count(5'd16);
        test_random_traffic(40);

        hold_until_drained();
        repeat (2 * DRAIN_CYCLES) @(posedge clk);
        if (pending_results.size() != 0) error_count++;

        if (error_count == 0)
        begin
            $display("tb_top: clean");
        end
        else
        begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
